@@ sv/abgs_pkg.sv @@
// Shared types, constants and arithmetic helpers of the adaptive background subtractor.
package abgs_pkg;

   // Field and port widths.
   localparam int PIX_W       = 8;
   localparam int INDEX_W     = 16;
   localparam int OPCODE_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Default number of background entries.
   localparam int PIXEL_COUNT_DEFAULT = 65536;

   typedef logic [PIX_W-1:0] pixel_type;

   // Item opcodes; the fourth code carries no operation.
   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_LEARN  = 2'd1,
      OP_DETECT = 2'd2
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FG_THRESHOLD    = 2'd0,
      CSR_ADAPT_THRESHOLD = 2'd1,
      CSR_ADAPT_STEP      = 2'd2
   } csr_index_type;

   // Register values after reset.
   localparam pixel_type FG_THRESHOLD_RESET    = 8'd30;
   localparam pixel_type ADAPT_THRESHOLD_RESET = 8'd10;
   localparam pixel_type ADAPT_STEP_RESET      = 8'd1;

   // Difference clamped at zero.
   function automatic pixel_type sat_sub(input pixel_type a, input pixel_type b);
      sat_sub = (a > b) ? pixel_type'(a - b) : '0;
   endfunction

   // Sum clamped at full scale.
   function automatic pixel_type sat_add(input pixel_type a, input pixel_type b);
      logic [PIX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      sat_add = sum[PIX_W] ? '1 : sum[PIX_W-1:0];
   endfunction

   // Absolute difference of two grey levels.
   function automatic pixel_type abs_diff(input pixel_type a, input pixel_type b);
      abs_diff = (a > b) ? pixel_type'(a - b) : pixel_type'(b - a);
   endfunction

   // One approximate-median update: each step is withheld when the pixel lies
   // more than the threshold away on the opposite side.
   function automatic pixel_type adapt(input pixel_type bg, input pixel_type px,
                                       input pixel_type thr, input pixel_type step);
      pixel_type up;
      pixel_type dn;
      pixel_type addv;
      pixel_type subv;
      up   = sat_sub(bg, px);
      dn   = sat_sub(px, bg);
      addv = (up > thr) ? '0 : step;
      subv = (dn > thr) ? '0 : step;
      adapt = sat_sub(sat_add(bg, addv), subv);
   endfunction

endpackage

@@ sv/adaptive_background_subtractor_unit.sv @@
// Top level of the adaptive background subtractor: background memory and update pipeline.
//
// The unit takes one pixel transfer per clock while req_ready is high and returns one result
// per pixel through stage 1, stage 2 and the stage 3 output register. Throughput is one
// pixel per cycle when the result side keeps up, set by the single read and single write
// port of the background memory and the read-modify-write of each entry; a pixel that
// follows an update of the same position picks up the new value through a forwarding
// path, so repeated positions run at full rate. The memory holds PIXEL_COUNT grey levels
// and has no reset: learning or detecting at a position that was never loaded returns an
// undefined background. A position at or above PIXEL_COUNT leaves the memory alone and
// returns zero. Configuration registers may be written only while no pixel is in flight.
module adaptive_background_subtractor_unit
   import abgs_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Pixel request channel.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic [INDEX_W-1:0]     req_pixel_index,
   input  logic [PIX_W-1:0]       req_pixel_value,
   // Result channel.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_foreground,
   output logic [PIX_W-1:0]       rsp_background_value,
   // Configuration write port.
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   typedef logic [ADDR_W-1:0] addr_type;

   // Configuration registers.
   pixel_type fg_threshold_ff;
   pixel_type adapt_threshold_ff;
   pixel_type adapt_step_ff;

   // Background memory.
   pixel_type mem [PIXEL_COUNT];
   pixel_type mem_rd_ff;
   logic      mem_wr_en;

   // Handshake and stage advance.
   logic s1_load;
   logic s2_load;
   logic s3_load;
   logic req_accept;
   logic req_in_range;
   addr_type req_addr;

   // Stage 1: memory read data and request fields.
   logic                s1_valid_ff;
   logic [OPCODE_W-1:0] s1_op_ff;
   addr_type            s1_addr_ff;
   pixel_type           s1_px_ff;
   logic                s1_in_range_ff;
   logic                s1_fwd_hit_ff;
   pixel_type           s1_fwd_data_ff;
   pixel_type           s1_bg_old;
   pixel_type           s1_bg_new;
   logic                s1_writes;

   // Stage 2: old and new background.
   logic      s2_valid_ff;
   logic      s2_detect_ff;
   logic      s2_in_range_ff;
   pixel_type s2_px_ff;
   pixel_type s2_bg_old_ff;
   pixel_type s2_bg_new_ff;

   // Stage 3: output register.
   logic      s3_valid_ff;
   logic      s3_fg_ff;
   pixel_type s3_bg_ff;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_threshold_ff    <= FG_THRESHOLD_RESET;
         adapt_threshold_ff <= ADAPT_THRESHOLD_RESET;
         adapt_step_ff      <= ADAPT_STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FG_THRESHOLD:    fg_threshold_ff    <= csr_data;
            CSR_ADAPT_THRESHOLD: adapt_threshold_ff <= csr_data;
            CSR_ADAPT_STEP:      adapt_step_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Each stage moves on when it is empty or the next stage takes its item.
   assign s3_load    = !s3_valid_ff || rsp_ready;
   assign s2_load    = !s2_valid_ff || s3_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_ready  = s1_load;
   assign req_accept = req_valid && s1_load;

   assign req_in_range = (32'(req_pixel_index) < 32'(PIXEL_COUNT));
   assign req_addr     = addr_type'(req_pixel_index);

   // Memory read at the transfer of a request.
   always_ff @(posedge clock) begin
      if (req_accept && req_in_range) begin
         mem_rd_ff <= mem[req_addr];
      end
   end

   // Memory write as an item leaves stage 1.
   assign mem_wr_en = s1_valid_ff && s2_load && s1_in_range_ff && s1_writes;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[s1_addr_ff] <= s1_bg_new;
      end
   end

   // Stage 1 valid bit and forwarding flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_fwd_hit_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff   <= req_valid;
         s1_fwd_hit_ff <= req_valid && mem_wr_en && (s1_addr_ff == req_addr);
      end
   end

   // Stage 1 payload. A write landing in the same cycle as the read is captured here,
   // since the read returns the entry as it was before that write.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff       <= req_opcode;
         s1_addr_ff     <= req_addr;
         s1_px_ff       <= req_pixel_value;
         s1_in_range_ff <= req_in_range;
         s1_fwd_data_ff <= s1_bg_new;
      end
   end

   // Background update: load replaces, learn and detect adapt, the spare code keeps.
   always_comb begin
      s1_bg_old = s1_fwd_hit_ff ? s1_fwd_data_ff : mem_rd_ff;
      s1_writes = 1'b1;
      case (s1_op_ff)
         OP_LOAD:   s1_bg_new = s1_px_ff;
         OP_LEARN,
         OP_DETECT: s1_bg_new = adapt(s1_bg_old, s1_px_ff, adapt_threshold_ff,
                                      adapt_step_ff);
         default: begin
            s1_bg_new = s1_bg_old;
            s1_writes = 1'b0;
         end
      endcase
   end

   // Stage 2 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         s2_detect_ff   <= (s1_op_ff == OP_DETECT);
         s2_in_range_ff <= s1_in_range_ff;
         s2_px_ff       <= s1_px_ff;
         s2_bg_old_ff   <= s1_bg_old;
         s2_bg_new_ff   <= s1_bg_new;
      end
   end

   // Stage 3: foreground decision against the old background.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_load) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_load && s2_valid_ff) begin
         s3_fg_ff <= s2_in_range_ff && s2_detect_ff &&
                     (abs_diff(s2_px_ff, s2_bg_old_ff) > fg_threshold_ff);
         s3_bg_ff <= s2_in_range_ff ? s2_bg_new_ff : '0;
      end
   end

   assign rsp_valid            = s3_valid_ff;
   assign rsp_foreground       = s3_fg_ff;
   assign rsp_background_value = s3_bg_ff;

`ifndef ASSERT_OFF
   // A memory write only happens when a stage 1 item moves on.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (s1_valid_ff && s2_load))
      else $error("background write without a stage 1 transfer");

   // A request transfer always lands in stage 1.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted pixel lost at stage 1");

   // A freshly loaded forwarding flag is only set by a write in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fwd_hit_ff && $past(s1_load) && !$past(reset)) |-> $past(mem_wr_en))
      else $error("forwarding hit without a matching write");

   // An item held in stage 1 sees no memory write to stale its read data.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> !$past(mem_wr_en))
      else $error("memory written while stage 1 was stalled");
`endif

endmodule
